### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge, off while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// implication on the same edge
`define ASSERT_IMPL(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// implication at the next edge
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

### hdl/zsts_pkg.sv
// ----------------------------------------------------------------------------
// zsts_pkg
// constants shared by the zero-sum triplet search
// ----------------------------------------------------------------------------
package zsts_pkg;

   localparam int MAX_RESULTS = 56;
   localparam int FOUND_W     = $clog2(MAX_RESULTS + 1);

   // result tuser layout
   localparam int USER_W         = 2;
   localparam int USER_VALID_BIT = 0;
   localparam int USER_DROP_BIT  = 1;

endpackage

### hdl/zero_sum_triplet_search.sv
// ----------------------------------------------------------------------------
// zero_sum_triplet_search
// sorted insert of a value stream, then a two-pointer search for the first MAX_RESULTS
// distinct triplets that sum to zero
// ----------------------------------------------------------------------------
//  channel  direction  words
//  req      in         one signed value each, tlast starts the search
//  rsp      out        one triplet each, tlast on the last of the run, which may be empty
//
//  each value, the final one too, is inserted in place over all cells in parallel
//  the final word runs the search on one shared read port and sum/compare
//  req_tready is low for the whole search; a held result stalls the search
//  reset clears the count, the drop flag and the control, not the store
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module zero_sum_triplet_search #(
   parameter int MAX_ITEMS   = 16,
   parameter int VALUE_WIDTH = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [((VALUE_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,   // value
   input  logic req_tlast,                                       // final_item
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [((3 * VALUE_WIDTH + 7) / 8) * 8 - 1:0] rsp_tdata, // smallest, middle, largest
   output logic [zsts_pkg::USER_W-1:0] rsp_tuser,               // triplet_valid, dropped
   output logic rsp_tlast                                        // run_end
);
   import zsts_pkg::*;

   localparam int IDX_W = $clog2(MAX_ITEMS);
   localparam int CNT_W = $clog2(MAX_ITEMS + 1);
   localparam int SUM_W = VALUE_WIDTH + 2;
   localparam int OUT_W = ((3 * VALUE_WIDTH + 7) / 8) * 8;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;

   typedef enum logic [2:0] {
      ST_LOAD, ST_ANCHOR, ST_FETCH_LO, ST_FETCH_HI, ST_CHECK, ST_FINISH
   } state_type;

   state_type            state_ff;
   value_type            store_ff [MAX_ITEMS];
   value_type            store_in [MAX_ITEMS];
   logic [MAX_ITEMS-1:0] gtm;
   logic [CNT_W-1:0]     count_ff;
   logic                 ovf_ff;
   logic [IDX_W-1:0]     i_ff, lo_ff, hi_ff;
   logic [FOUND_W-1:0]   found_ff;
   logic                 fetch_both_ff;
   value_type            a_val_ff, lo_val_ff, hi_val_ff, lo_prev_ff, hi_prev_ff;
   logic                 pend_ff;
   value_type            pend_a_ff, pend_b_ff, pend_c_ff;
   logic                 rsp_tvalid_ff, rsp_tlast_ff;
   value_type            out_a_ff, out_b_ff, out_c_ff;
   logic                 out_valid_ff, out_drop_ff;

   value_type            req_value;
   logic                 req_fire, out_free, has_room;
   logic [IDX_W-1:0]     rd_idx;
   value_type            rd_val;
   logic signed [SUM_W-1:0] sum;
   logic                 anchor_ok, below_limit, lo_first, hi_last, lo_dup, hi_dup;
   logic                 emit_hit, out_load;

   assign req_value = value_type'(req_tdata[VALUE_WIDTH-1:0]);
   assign req_tready = (state_ff == ST_LOAD);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign has_room   = count_ff < CNT_W'(MAX_ITEMS);

   // insertion: every cell decides in parallel whether to shift up
   for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
      assign gtm[g] = (CNT_W'(g) < count_ff) && (store_ff[g] > req_value);
      if (g == 0) begin : g_first
         assign store_in[g] = (gtm[g] || count_ff == CNT_W'(g)) ? req_value : store_ff[g];
      end else begin : g_rest
         assign store_in[g] = (gtm[g] || count_ff == CNT_W'(g)) ?
                              (gtm[g-1] ? store_ff[g-1] : req_value) : store_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && has_room) begin
         store_ff <= store_in;
      end
   end

   // shared read port and sum/compare unit
   always_comb begin
      unique case (state_ff)
         ST_FETCH_LO: rd_idx = lo_ff;
         ST_FETCH_HI: rd_idx = hi_ff;
         default:     rd_idx = i_ff;
      endcase
   end
   assign rd_val = store_ff[rd_idx];

   assign sum = SUM_W'(a_val_ff) + SUM_W'(lo_val_ff) + SUM_W'(hi_val_ff);
   assign anchor_ok   = ((CNT_W + 1)'(i_ff) + (CNT_W + 1)'(2)) < (CNT_W + 1)'(count_ff);
   assign below_limit = found_ff < FOUND_W'(MAX_RESULTS);
   assign lo_first    = (IDX_W + 1)'(lo_ff) == (IDX_W + 1)'(i_ff) + (IDX_W + 1)'(1);
   assign hi_last     = CNT_W'(hi_ff) == count_ff - CNT_W'(1);
   assign lo_dup      = !lo_first && (lo_val_ff == lo_prev_ff);
   assign hi_dup      = !hi_last && (hi_val_ff == hi_prev_ff);

   // output register loads on a pushed-out triplet or on the closing word
   assign emit_hit = (lo_ff < hi_ff) && below_limit && !lo_dup && !hi_dup && (sum == 0);
   assign out_load = ((state_ff == ST_CHECK) && emit_hit && pend_ff && out_free) ||
                     ((state_ff == ST_FINISH) && out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
         pend_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         found_ff      <= '0;
         i_ff          <= '0;
         fetch_both_ff <= 1'b0;
      end else begin
         if (out_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tvalid_ff && rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_LOAD: begin
               if (req_fire) begin
                  if (has_room) begin
                     count_ff <= count_ff + CNT_W'(1);
                  end else begin
                     ovf_ff <= 1'b1;
                  end
                  if (req_tlast) begin
                     i_ff     <= '0;
                     found_ff <= '0;
                     pend_ff  <= 1'b0;
                     state_ff <= ST_ANCHOR;
                  end
               end
            end
            ST_ANCHOR: begin
               if (anchor_ok && below_limit) begin
                  if (i_ff != '0 && rd_val == a_val_ff) begin
                     i_ff <= i_ff + IDX_W'(1);
                  end else begin
                     a_val_ff      <= rd_val;
                     lo_ff         <= i_ff + IDX_W'(1);
                     hi_ff         <= IDX_W'(count_ff - CNT_W'(1));
                     fetch_both_ff <= 1'b1;
                     state_ff      <= ST_FETCH_LO;
                  end
               end else begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FETCH_LO: begin
               lo_val_ff <= rd_val;
               state_ff  <= fetch_both_ff ? ST_FETCH_HI : ST_CHECK;
            end
            ST_FETCH_HI: begin
               hi_val_ff <= rd_val;
               state_ff  <= ST_CHECK;
            end
            ST_CHECK: begin
               if (!(lo_ff < hi_ff && below_limit)) begin
                  i_ff     <= i_ff + IDX_W'(1);
                  state_ff <= ST_ANCHOR;
               end else if (lo_dup || (!hi_dup && sum < 0)) begin
                  lo_prev_ff    <= lo_val_ff;
                  lo_ff         <= lo_ff + IDX_W'(1);
                  fetch_both_ff <= 1'b0;
                  state_ff      <= ST_FETCH_LO;
               end else if (hi_dup || sum > 0) begin
                  hi_prev_ff <= hi_val_ff;
                  hi_ff      <= hi_ff - IDX_W'(1);
                  state_ff   <= ST_FETCH_HI;
               end else if (!pend_ff || out_free) begin
                  // hold the new triplet, push the older one out
                  if (pend_ff) begin
                     out_a_ff      <= pend_a_ff;
                     out_b_ff      <= pend_b_ff;
                     out_c_ff      <= pend_c_ff;
                     out_valid_ff  <= 1'b1;
                     out_drop_ff   <= ovf_ff;
                     rsp_tlast_ff  <= 1'b0;
                  end
                  pend_ff       <= 1'b1;
                  pend_a_ff     <= a_val_ff;
                  pend_b_ff     <= lo_val_ff;
                  pend_c_ff     <= hi_val_ff;
                  found_ff      <= found_ff + FOUND_W'(1);
                  lo_prev_ff    <= lo_val_ff;
                  hi_prev_ff    <= hi_val_ff;
                  lo_ff         <= lo_ff + IDX_W'(1);
                  hi_ff         <= hi_ff - IDX_W'(1);
                  fetch_both_ff <= 1'b1;
                  state_ff      <= ST_FETCH_LO;
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  out_a_ff      <= pend_ff ? pend_a_ff : '0;
                  out_b_ff      <= pend_ff ? pend_b_ff : '0;
                  out_c_ff      <= pend_ff ? pend_c_ff : '0;
                  out_valid_ff  <= pend_ff;
                  out_drop_ff   <= ovf_ff;
                  rsp_tlast_ff  <= 1'b1;
                  pend_ff       <= 1'b0;
                  count_ff      <= '0;
                  ovf_ff        <= 1'b0;
                  state_ff      <= ST_LOAD;
               end
            end
            default: state_ff <= ST_LOAD;
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tlast  = rsp_tlast_ff;
   assign rsp_tdata  = OUT_W'({out_c_ff, out_b_ff, out_a_ff});
   always_comb begin
      rsp_tuser                 = '0;
      rsp_tuser[USER_VALID_BIT] = out_valid_ff;
      rsp_tuser[USER_DROP_BIT]  = out_drop_ff;
   end

   `ASSERT_CLK(a_count_bound, clock, reset, count_ff <= CNT_W'(MAX_ITEMS), "count above capacity")
   `ASSERT_IMPL(a_lo_above_anchor, clock, reset, state_ff == ST_CHECK, lo_ff > i_ff, "lo at or below anchor")
   `ASSERT_NEXT(a_final_blocks, clock, reset, req_fire && req_tlast, !req_tready, "ready after final word")
   `ASSERT_IMPL(a_empty_is_last, clock, reset, rsp_tvalid && !rsp_tuser[USER_VALID_BIT], rsp_tlast, "empty result not last")

endmodule
